// File: hdl/vid_pkg.sv
// Shared types and constants for the vector instruction decode and hazard unit.
`timescale 1ns / 1ps
`default_nettype none

package vid_pkg;

	localparam int REG_W = 5;
	localparam int NUM_VECTOR_REGS = 32;
	localparam int MAX_LENGTH = 1024;

	// Instruction classes.
	localparam logic [1:0] CLS_INVALID = 2'd0;
	localparam logic [1:0] CLS_MEM     = 2'd1;
	localparam logic [1:0] CLS_ARITH   = 2'd2;
	localparam logic [1:0] CLS_VSET    = 2'd3;

	// Status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ENC   = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// Latency classes.
	localparam logic [3:0] LAT_MEM    = 4'd10;
	localparam logic [3:0] LAT_MULDIV = 4'd5;
	localparam logic [3:0] LAT_ALU    = 4'd2;
	localparam logic [3:0] LAT_VSET   = 4'd1;

	// Major opcodes and the funct3 value that selects length setting.
	localparam logic [6:0] OP_VLOAD  = 7'h07;
	localparam logic [6:0] OP_VSTORE = 7'h27;
	localparam logic [6:0] OP_VFMA   = 7'h43;
	localparam logic [6:0] OP_VEC    = 7'h57;
	localparam logic [2:0] F3_VSET   = 3'd7;

	// Memory subtypes.
	localparam logic [2:0] MK_UNIT    = 3'd0;
	localparam logic [2:0] MK_STRIDED = 3'd1;
	localparam logic [2:0] MK_INDEXED = 3'd2;
	localparam logic [2:0] MK_SEGMENT = 3'd3;
	localparam logic [2:0] MK_WHOLE   = 3'd4;

	// Arithmetic subtypes.
	localparam logic [3:0] AK_ADD   = 4'd0;
	localparam logic [3:0] AK_SUB   = 4'd1;
	localparam logic [3:0] AK_MUL   = 4'd2;
	localparam logic [3:0] AK_DIV   = 4'd3;
	localparam logic [3:0] AK_AND   = 4'd4;
	localparam logic [3:0] AK_OR    = 4'd5;
	localparam logic [3:0] AK_XOR   = 4'd6;
	localparam logic [3:0] AK_SHIFT = 4'd7;
	localparam logic [3:0] AK_CMP   = 4'd8;

	typedef struct packed {
		logic [31:0] instr_word;
	} instr_t;

	typedef struct packed {
		logic [1:0]       instr_class;
		logic [2:0]       mem_kind;
		logic [3:0]       arith_kind;
		logic [REG_W-1:0] dest_reg;
		logic [REG_W-1:0] src_one_reg;
		logic [REG_W-1:0] src_two_reg;
		logic             masked;
		logic             touches_memory;
		logic [3:0]       latency_class;
		logic [4:0]       length_field;
		logic [1:0]       status;
		logic             hazard_prev;
	} result_t;

	// Decoded instruction as it sits in the queue between front and back.
	typedef struct packed {
		logic [1:0]       instr_class;
		logic [2:0]       mem_kind;
		logic [3:0]       arith_kind;
		logic [REG_W-1:0] dest_reg;
		logic [REG_W-1:0] src_one_reg;
		logic [REG_W-1:0] src_two_reg;
		logic             masked;
		logic             touches_memory;
		logic [3:0]       latency_class;
		logic [4:0]       length_field;
		logic [1:0]       status;
		logic             mask_use;
		logic             sets_length;
	} dec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

`default_nettype wire

// File: hdl/vid_chan_if.sv
// Valid/ready channel interface with a typed payload.
`timescale 1ns / 1ps
`default_nettype none

interface vid_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hdl/vector_instr_decode_hazard_unit.sv
// Top level of the vector instruction decode and hazard unit.
//
//   Channel   Direction   Payload
//   instr     in          vid_pkg::instr_t  (instr_word)
//   result    out         vid_pkg::result_t (decoded fields, status, hazard_prev)
//
// One instruction per cycle sustained while result.ready stays high. A word is decoded in the cycle
// of its transfer and written into the queue; the back end pops it from the queue and registers
// its result in the result register, from which it transfers on result.
// The back end compares each instruction combinationally against the last one that passed
// validation.
// Reset clears the queue, the result valid and the previous-instruction state.
// A stall on result fills the queue, and instr.ready drops once it is full.
`timescale 1ns / 1ps
`default_nettype none

module vector_instr_decode_hazard_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input wire logic   clk,
	input wire logic   arst_n,
	vid_chan_if.sink   instr,
	vid_chan_if.source result
);
	import vid_pkg::*;

	dec_t        q_wdata;
	dec_t        q_rdata;
	logic        q_push;
	logic        q_pop;
	queue_stat_t q_stat;

	vid_front u_front (
		.instr   (instr),
		.q_full  (q_stat.full),
		.q_wdata (q_wdata),
		.q_push  (q_push)
	);

	vid_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	vid_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (~q_stat.empty),
		.q_rdata (q_rdata),
		.q_pop   (q_pop),
		.result  (result)
	);

`ifndef SYNTHESIS
	a_queue_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty at once");

	a_invalid_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.payload.instr_class == CLS_INVALID)
			|-> (result.payload.status == ST_ENC && !result.payload.hazard_prev))
		else $error("invalid instruction carries a hazard or wrong status");

	a_memory_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.payload.touches_memory)
			|-> (result.payload.instr_class == CLS_MEM
				&& result.payload.latency_class == LAT_MEM))
		else $error("memory flag disagrees with class or latency");

	a_pop_only_when_queued: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("back end popped an empty queue");
`endif

endmodule

`default_nettype wire

// File: hdl/vid_front.sv
// Front end: accepts instruction words, decodes and validates them into the queue.
`timescale 1ns / 1ps
`default_nettype none

module vid_front (
	vid_chan_if.sink     instr,
	input  wire logic    q_full,
	output vid_pkg::dec_t q_wdata,
	output logic         q_push
);
	import vid_pkg::*;

	localparam logic [REG_W:0] REG_LIM = (REG_W + 1)'(NUM_VECTOR_REGS);
	localparam logic [16:0]    LEN_LIM = 17'(MAX_LENGTH);

	logic [31:0]      word;
	logic [6:0]       op;
	logic [2:0]       f3;
	logic [5:0]       f6;
	logic [REG_W-1:0] vd;
	logic [REG_W-1:0] vs1;
	logic [REG_W-1:0] vs2;
	logic [1:0]       cls;
	logic             out_of_range;
	dec_t             dec;

	function automatic logic [2:0] mem_kind_of(input logic [2:0] code);
		logic [2:0] kind;
		unique case (code)
			3'd2:    kind = MK_STRIDED;
			3'd3:    kind = MK_INDEXED;
			3'd1:    kind = MK_SEGMENT;
			3'd4:    kind = MK_WHOLE;
			default: kind = MK_UNIT;
		endcase
		return kind;
	endfunction

	function automatic logic [3:0] arith_kind_of(input logic [5:0] code);
		logic [3:0] kind;
		unique case (code) inside
			6'h02:                      kind = AK_SUB;
			6'h25:                      kind = AK_MUL;
			6'h20:                      kind = AK_DIV;
			6'h24:                      kind = AK_AND;
			6'h28:                      kind = AK_OR;
			6'h2C:                      kind = AK_XOR;
			6'h30, 6'h34, 6'h38:        kind = AK_SHIFT;
			6'h18, 6'h19, 6'h1A, 6'h1B: kind = AK_CMP;
			default:                    kind = AK_ADD;
		endcase
		return kind;
	endfunction

	assign word = instr.payload.instr_word;
	assign op   = word[6:0];
	assign f3   = word[14:12];
	assign f6   = word[31:26];
	assign vd   = word[11:7];
	assign vs1  = word[19:15];
	assign vs2  = word[24:20];

	always_comb begin
		unique case (op) inside
			OP_VLOAD, OP_VSTORE: cls = CLS_MEM;
			OP_VFMA:             cls = CLS_ARITH;
			OP_VEC:              cls = (f3 == F3_VSET) ? CLS_VSET : CLS_ARITH;
			default:             cls = CLS_INVALID;
		endcase
	end

	assign out_of_range = ({1'b0, vd} >= REG_LIM) || ({1'b0, vs1} >= REG_LIM)
		|| ({1'b0, vs2} >= REG_LIM);

	always_comb begin
		dec = '0;
		if (cls == CLS_INVALID) begin
			// Undecodable words carry nothing but the encoding error.
			dec.status = ST_ENC;
		end else begin
			dec.instr_class = cls;
			dec.dest_reg    = vd;
			dec.src_one_reg = vs1;
			dec.src_two_reg = vs2;
			dec.masked      = ~word[25];
			unique case (cls)
				CLS_MEM: begin
					dec.mem_kind       = mem_kind_of(f3);
					dec.touches_memory = 1'b1;
					dec.mask_use       = ~word[25];
					dec.latency_class  = LAT_MEM;
				end
				CLS_ARITH: begin
					dec.arith_kind    = arith_kind_of(f6);
					dec.mask_use      = ~word[25];
					dec.latency_class = (dec.arith_kind == AK_MUL || dec.arith_kind == AK_DIV)
						? LAT_MULDIV : LAT_ALU;
				end
				default: begin
					dec.length_field  = vs1;
					dec.sets_length   = 1'b1;
					dec.latency_class = LAT_VSET;
				end
			endcase
			if (out_of_range) begin
				dec.status = ST_RANGE;
			end else if (cls == CLS_MEM && dec.mask_use && vd == '0) begin
				dec.status = ST_ENC;
			end else if (cls == CLS_VSET && 17'(vs1) > LEN_LIM) begin
				dec.status = ST_RANGE;
			end else begin
				dec.status = ST_OK;
			end
		end
	end

	assign instr.ready = ~q_full;
	assign q_push      = instr.valid & ~q_full;
	assign q_wdata     = dec;

endmodule

`default_nettype wire

// File: hdl/vid_queue.sv
// Short queue of decoded instructions between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module vid_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire vid_pkg::dec_t wdata,
	input  wire logic          pop,
	output vid_pkg::dec_t      rdata,
	output vid_pkg::queue_stat_t stat
);
	import vid_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	dec_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (count_q == FULL_CNT);
	assign stat.empty = (count_q == '0);
	assign do_push    = push & ~stat.full;
	assign do_pop     = pop & ~stat.empty;
	assign rdata      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/vid_back.sv
// Back end: hazard check against the last instruction that passed validation and the result register.
`timescale 1ns / 1ps
`default_nettype none

module vid_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  wire vid_pkg::dec_t q_rdata,
	output logic               q_pop,
	vid_chan_if.source         result
);
	import vid_pkg::*;

	logic             prev_valid_q;
	logic [REG_W-1:0] prev_dest_q;
	logic [REG_W-1:0] prev_src_one_q;
	logic [REG_W-1:0] prev_src_two_q;
	logic             prev_masked_q;
	logic             prev_memory_q;
	logic             prev_sets_length_q;
	logic             res_valid_q;
	result_t          res_q;
	dec_t             d;
	logic             hazard;

	assign d = q_rdata;

	always_comb begin
		hazard = 1'b0;
		if (prev_valid_q && d.instr_class != CLS_INVALID) begin
			hazard = prev_sets_length_q || d.sets_length
				|| (prev_dest_q == d.dest_reg)
				|| (prev_dest_q == d.src_one_reg) || (prev_dest_q == d.src_two_reg)
				|| (d.dest_reg == prev_src_one_q) || (d.dest_reg == prev_src_two_q)
				|| ((prev_masked_q || d.mask_use)
					&& (prev_dest_q == '0 || d.dest_reg == '0))
				|| (prev_memory_q && d.touches_memory);
		end
	end

	// The result register frees up in the same cycle its transfer completes.
	assign q_pop = q_valid & (~res_valid_q | result.ready);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q.instr_class    <= d.instr_class;
			res_q.mem_kind       <= d.mem_kind;
			res_q.arith_kind     <= d.arith_kind;
			res_q.dest_reg       <= d.dest_reg;
			res_q.src_one_reg    <= d.src_one_reg;
			res_q.src_two_reg    <= d.src_two_reg;
			res_q.masked         <= d.masked;
			res_q.touches_memory <= d.touches_memory;
			res_q.latency_class  <= d.latency_class;
			res_q.length_field   <= d.length_field;
			res_q.status         <= d.status;
			res_q.hazard_prev    <= hazard;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q        <= 1'b0;
			prev_valid_q       <= 1'b0;
			prev_dest_q        <= '0;
			prev_src_one_q     <= '0;
			prev_src_two_q     <= '0;
			prev_masked_q      <= 1'b0;
			prev_memory_q      <= 1'b0;
			prev_sets_length_q <= 1'b0;
		end else begin
			if (q_pop) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			// Only instructions that pass validation become the comparison point.
			if (q_pop && d.status == ST_OK) begin
				prev_valid_q       <= 1'b1;
				prev_dest_q        <= d.dest_reg;
				prev_src_one_q     <= d.src_one_reg;
				prev_src_two_q     <= d.src_two_reg;
				prev_masked_q      <= d.mask_use;
				prev_memory_q      <= d.touches_memory;
				prev_sets_length_q <= d.sets_length;
			end
		end
	end

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

endmodule

`default_nettype wire
